// ===== src/dpf_pkg.sv =====
// ----------------------------------------------------------------------------
// dpf_pkg
// Types and constants shared by the duplicate packet filter modules.
// ----------------------------------------------------------------------------
package dpf_pkg;

  localparam int ENTRIES   = 32;
  localparam int ID_W      = 32;
  localparam int SEQ_W     = 8;
  localparam int VERDICT_W = 3;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int FILL_W    = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SEQ_W-1:0] seq;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_SEQ_ZERO  = 3'd0,
    VERDICT_PUBLIC    = 3'd1,
    VERDICT_NEW_SEQ   = 3'd2,
    VERDICT_DUPLICATE = 3'd3,
    VERDICT_STORED    = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_t;

endpackage

// ===== src/dpf_if.sv =====
// ----------------------------------------------------------------------------
// dpf_in_if / dpf_out_if
// Valid/ready channels for received packets and filter results.
// ----------------------------------------------------------------------------
interface dpf_in_if;
  logic                     valid;
  logic                     ready;
  logic [dpf_pkg::ID_W-1:0]  sender_id;
  logic [dpf_pkg::SEQ_W-1:0] seq_num;

  modport source (output valid, output sender_id, output seq_num, input ready);
  modport sink   (input valid, input sender_id, input seq_num, output ready);
endinterface

interface dpf_out_if;
  logic                         valid;
  logic                         ready;
  logic                         forward;
  logic [dpf_pkg::VERDICT_W-1:0] verdict;

  modport source (output valid, output forward, output verdict, input ready);
  modport sink   (input valid, input forward, input verdict, output ready);
endinterface

// ===== src/dpf_ram.sv =====
// ----------------------------------------------------------------------------
// dpf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dpf_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/dpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpf_ctrl
// Sequencer: walks the sender table, updates or inserts, registers the result.
// ----------------------------------------------------------------------------
module dpf_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  dpf_in_if.sink                     pkt_in,
  dpf_out_if.source                  res_out,
  output logic                       ram_we,
  output logic [dpf_pkg::IDX_W-1:0]  ram_waddr,
  output dpf_pkg::entry_t            ram_wdata,
  output logic                       ram_re,
  output logic [dpf_pkg::IDX_W-1:0]  ram_raddr,
  input  dpf_pkg::entry_t            ram_rdata
);
  import dpf_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [ID_W-1:0]   id_q;
  logic [SEQ_W-1:0]  seq_q;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  ptr;
  logic [FILL_W-1:0] fill;
  verdict_t          verdict_q;
  logic              res_valid;
  logic              res_forward;
  verdict_t          res_verdict;

  logic trivial;
  logic idx_valid;
  logic hit;
  logic last;
  logic out_free;

  assign trivial   = (pkt_in.seq_num == '0) || (pkt_in.sender_id == '0);
  assign idx_valid = {1'b0, idx} < fill;
  assign hit       = idx_valid && (ram_rdata.id == id_q);
  assign last      = !hit && ((idx == IDX_W'(ENTRIES - 1)) ||
                              (({1'b0, idx} + FILL_W'(1)) >= fill));
  assign out_free  = !res_valid || res_out.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pkt_in.valid) begin
          state_next = trivial ? S_DONE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit || last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pkt_in.ready = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = idx + IDX_W'(1);
    ram_we       = 1'b0;
    ram_waddr    = hit ? idx : ptr;
    ram_wdata    = '{id: id_q, seq: seq_q};
    unique case (state)
      S_IDLE: begin
        pkt_in.ready = 1'b1;
        ram_re       = pkt_in.valid && !trivial;
        ram_raddr    = '0;
      end
      S_SEARCH: begin
        ram_re = !hit && !last;
        ram_we = (hit && (ram_rdata.seq != seq_q)) || last;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      fill      <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SEARCH && last) begin
        ptr <= (ptr == IDX_W'(ENTRIES - 1)) ? '0 : ptr + IDX_W'(1);
        if (fill != FILL_W'(ENTRIES)) begin
          fill <= fill + FILL_W'(1);
        end
      end
      if (state == S_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (res_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (pkt_in.valid) begin
          id_q      <= pkt_in.sender_id;
          seq_q     <= pkt_in.seq_num;
          idx       <= '0;
          verdict_q <= (pkt_in.seq_num == '0) ? VERDICT_SEQ_ZERO : VERDICT_PUBLIC;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          verdict_q <= (ram_rdata.seq == seq_q) ? VERDICT_DUPLICATE : VERDICT_NEW_SEQ;
        end else if (last) begin
          verdict_q <= VERDICT_STORED;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_verdict <= verdict_q;
          res_forward <= (verdict_q != VERDICT_DUPLICATE);
        end
      end
      default: begin
      end
    endcase
  end

  assign res_out.valid   = res_valid;
  assign res_out.forward = res_forward;
  assign res_out.verdict = res_verdict;

endmodule

// ===== src/duplicate_packet_filter_top.sv =====
// ----------------------------------------------------------------------------
// duplicate_packet_filter_top
// Marks repeated packets not to be forwarded by tracking the last sequence number per sender.
// ----------------------------------------------------------------------------
// One packet is handled at a time. A packet with sequence zero or sender id
// zero skips the table and goes straight to the result. Any other packet
// walks the sender table in RAM one entry per cycle, stopping at the first
// match or at the last filled entry; the single RAM read port sets this pace.
// The table starts empty after reset through a fill count, with no clearing
// pass. Results sit in an output register, so a result may wait on the sink
// while the block finishes its current lookup; a lookup that ends while the
// previous result still waits holds until the sink takes it.
module duplicate_packet_filter_top (
  input  logic      clk,
  input  logic      rst,
  dpf_in_if.sink    pkt_in,
  dpf_out_if.source res_out
);
  import dpf_pkg::*;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  assign ram_rdata = entry_t'(ram_rdata_raw);

  dpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pkt_in    (pkt_in),
    .res_out   (res_out),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  dpf_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (ENTRY_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

endmodule
